### hw/rtl/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

	localparam int MAX_RADIUS   = 7;
	localparam int STORE_DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int SAMPLE_W     = 8;
	localparam int RAD_W        = 3;
	localparam int AGE_W        = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
	localparam int HI_W         = (AGE_W > RAD_W + 1) ? AGE_W : RAD_W + 1;
	localparam int CMP_W        = (CNT_W > RAD_W + 1) ? CNT_W : RAD_W + 1;
	localparam int TREE_N       = 2 ** AGE_W;
	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_in_line;
	} in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] max_value;
		logic [SAMPLE_W-1:0] min_value;
		logic                last_out;
	} out_t;

	// one queued job: window snapshot and the range of positions to emit
	typedef struct packed {
		logic [STORE_DEPTH-1:0][SAMPLE_W-1:0] win;
		logic [RAD_W-1:0]                     radius;
		logic [AGE_W-1:0]                     vmax;
		logic [RAD_W-1:0]                     qfirst;
		logic                                 last;
	} job_t;

endpackage

`default_nettype wire

### hw/rtl/swmm_fifo.sv
`default_nettype none

module swmm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire swmm_pkg::job_t push_data,
	output logic                push_ready,
	input  wire logic           pop,
	output swmm_pkg::job_t      pop_data,
	output logic                pop_valid
);

	swmm_pkg::job_t                          data_q [swmm_pkg::FIFO_DEPTH];
	logic [swmm_pkg::FIFO_PTR_W-1:0]         wr_ptr_q;
	logic [swmm_pkg::FIFO_PTR_W-1:0]         rd_ptr_q;
	logic [swmm_pkg::FIFO_CNT_W-1:0]         count_q;
	logic                                    do_push;
	logic                                    do_pop;

	assign push_ready = count_q != swmm_pkg::FIFO_CNT_W'(swmm_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = data_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == swmm_pkg::FIFO_PTR_W'(swmm_pkg::FIFO_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == swmm_pkg::FIFO_PTR_W'(swmm_pkg::FIFO_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= swmm_pkg::FIFO_CNT_W'(swmm_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

### hw/rtl/swmm_front.sv
`default_nettype none

module swmm_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [swmm_pkg::RAD_W-1:0]   radius,
	input  wire logic                         accept,
	input  wire swmm_pkg::in_t                item,
	output logic                              push,
	output swmm_pkg::job_t                    job
);

	logic [swmm_pkg::STORE_DEPTH-1:0][swmm_pkg::SAMPLE_W-1:0] store_q;
	logic [swmm_pkg::CNT_W-1:0]                                seen_q;
	logic [swmm_pkg::RAD_W-1:0]                                r_eff;
	logic [swmm_pkg::CMP_W-1:0]                                n_cmp;
	logic [swmm_pkg::CMP_W-1:0]                                r_cmp;
	logic                                                      n_ge_r;

	always_comb begin
		r_eff = (swmm_pkg::CMP_W'(radius) > swmm_pkg::CMP_W'(swmm_pkg::MAX_RADIUS))
			? swmm_pkg::RAD_W'(swmm_pkg::MAX_RADIUS) : radius;
		n_cmp = swmm_pkg::CMP_W'(seen_q);
		r_cmp = swmm_pkg::CMP_W'(r_eff);
		n_ge_r = n_cmp >= r_cmp;

		job.win[0] = item.sample;
		for (int a = 1; a < swmm_pkg::STORE_DEPTH; a++) begin
			job.win[a] = store_q[a-1];
		end
		job.radius = r_eff;
		job.vmax   = (seen_q >= swmm_pkg::CNT_W'(swmm_pkg::STORE_DEPTH - 1))
			? swmm_pkg::AGE_W'(swmm_pkg::STORE_DEPTH - 1) : swmm_pkg::AGE_W'(seen_q);
		job.qfirst = n_ge_r ? r_eff : swmm_pkg::RAD_W'(seen_q);
		job.last   = item.last_in_line;

		push = accept && (item.last_in_line || n_ge_r);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= job.win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (item.last_in_line) begin
				seen_q <= '0;
			end else if (seen_q != swmm_pkg::CNT_W'(swmm_pkg::STORE_DEPTH)) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/swmm_back.sv
`default_nettype none

module swmm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire swmm_pkg::job_t job_in,
	input  wire logic           job_valid,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_ready,
	output swmm_pkg::out_t      result
);

	swmm_pkg::job_t                   cur_q;
	logic                             cur_valid_q;
	logic [swmm_pkg::RAD_W-1:0]       q_q;
	swmm_pkg::out_t                   result_q;
	logic                             result_valid_q;

	logic                             adv;
	logic                             fin;
	logic [swmm_pkg::HI_W-1:0]        sum;
	logic [swmm_pkg::HI_W-1:0]        hi;
	logic [swmm_pkg::SAMPLE_W-1:0]    mx [swmm_pkg::TREE_N];
	logic [swmm_pkg::SAMPLE_W-1:0]    mn [swmm_pkg::TREE_N];
	swmm_pkg::out_t                   res_d;

	assign adv = cur_valid_q && (!result_valid_q || result_ready);
	assign fin = !cur_q.last || (q_q == '0);
	assign pop = job_valid && (!cur_valid_q || (adv && fin));

	// masked comparator tree over the window snapshot
	always_comb begin
		sum = swmm_pkg::HI_W'(q_q) + swmm_pkg::HI_W'(cur_q.radius);
		hi  = (sum > swmm_pkg::HI_W'(cur_q.vmax)) ? swmm_pkg::HI_W'(cur_q.vmax) : sum;
		for (int a = 0; a < swmm_pkg::TREE_N; a++) begin
			mx[a] = '0;
			mn[a] = '1;
		end
		for (int a = 0; a < swmm_pkg::STORE_DEPTH; a++) begin
			if (swmm_pkg::HI_W'(a) <= hi) begin
				mx[a] = cur_q.win[a];
				mn[a] = cur_q.win[a];
			end
		end
		for (int l = 0; l < swmm_pkg::AGE_W; l++) begin
			for (int i = 0; i < (swmm_pkg::TREE_N >> (l + 1)); i++) begin
				mx[i] = (mx[2*i] > mx[2*i+1]) ? mx[2*i] : mx[2*i+1];
				mn[i] = (mn[2*i] < mn[2*i+1]) ? mn[2*i] : mn[2*i+1];
			end
		end
		res_d.max_value = mx[0];
		res_d.min_value = mn[0];
		res_d.last_out  = cur_q.last && (q_q == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_d;
		end
		if (pop) begin
			cur_q <= job_in;
			q_q   <= job_in.qfirst;
		end else if (adv) begin
			q_q <= q_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (adv && fin) begin
				cur_valid_q <= 1'b0;
			end
			if (adv) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_last_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_q.last_out == $past(cur_q.last && fin))
		else $error("last flag does not match job end");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && !cur_q.last |-> q_q == cur_q.qfirst)
		else $error("mid-line job stepped past its one position");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cur_valid_q |-> adv && fin)
		else $error("job replaced before it finished");

endmodule

`default_nettype wire

### hw/rtl/sliding_window_max_min_filter.sv
`default_nettype none

// channel   | direction | handshake                     | payload
// sample    | in        | sample_valid / sample_ready   | sample_data  (in_t)
// result    | out       | result_valid / result_ready   | result_data  (out_t)
// cfg       | in        | cfg_we                        | cfg_wdata    (window radius)
//
// one sample accepted per cycle while the job queue has room; a mid-line sample's job
// passes the queue entry and the current-job register before its result is registered
// a line-end sample yields min(n, radius)+1 results, one per cycle from the comparator
// tree while result_ready holds, so the back end stays busy with it; the two-entry job
// queue may then fill and stall the sample channel
// arst_n clears the queue, the line position and the output valid; radius resets to 2
// a stalled result holds the back end but not the front until the queue is full

module sliding_window_max_min_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_valid,
	output logic                             sample_ready,
	input  wire swmm_pkg::in_t               sample_data,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output swmm_pkg::out_t                   result_data,
	input  wire logic                        cfg_we,
	input  wire logic [swmm_pkg::RAD_W-1:0]  cfg_wdata
);

	logic [swmm_pkg::RAD_W-1:0] radius_q;
	logic                       accept;
	logic                       push;
	logic                       push_ready;
	logic                       pop;
	logic                       job_valid;
	swmm_pkg::job_t             job_front;
	swmm_pkg::job_t             job_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= swmm_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	assign sample_ready = push_ready;
	assign accept       = sample_valid && push_ready;

	swmm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.radius (radius_q),
		.accept (accept),
		.item   (sample_data),
		.push   (push),
		.job    (job_front)
	);

	swmm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (job_front),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_data   (job_back),
		.pop_valid  (job_valid)
	);

	swmm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_in       (job_back),
		.job_valid    (job_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_data)
	);

endmodule

`default_nettype wire
